// File: rtl/odo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package odo_pkg;

  // register reset values and register indexes
  localparam logic [15:0] RADIUS_RESET = 16'd1343;
  localparam logic [15:0] AXLE_RESET   = 16'd3736;

  typedef enum logic {
    CFG_WHEEL_RADIUS = 1'b0,
    CFG_AXLE_LENGTH  = 1'b1
  } odo_cfg_t;

  // angle constants, units of 2^-24 rad
  localparam logic [31:0]        TWO_PI_MOD  = 32'd105414357;
  localparam int                 ANG_W       = 28;
  localparam logic signed [27:0] TWO_PI_Q24  = 28'sd105414357;
  localparam logic signed [27:0] PI_Q24      = 28'sd52707179;
  localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;

  // cordic working format Q2.30 with headroom
  localparam int                 XY_W         = 34;
  localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

  // shared multiplier operand widths
  localparam int MUL_A_W = 35;
  localparam int MUL_B_W = 17;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // heading divider: 32-bit magnitude shifted by 12, plus half divisor
  localparam int NUM_W  = 45;
  localparam int DCNT_W = 6;

  // accumulator for travel times cosine or sine
  localparam int ACC_W = 68;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRAV_SUM,
    S_TRAV_DIFF,
    S_TRAV_DONE,
    S_WAIT_CORDIC,
    S_X_LO,
    S_X_HI,
    S_Y_LO,
    S_Y_HI,
    S_Y_DONE,
    S_WAIT_DIV,
    S_FINISH
  } odo_state_t;

  typedef enum logic [2:0] {
    C_IDLE,
    C_REDUCE,
    C_FOLD,
    C_WRAP,
    C_ROTATE
  } odo_cordic_state_t;

  typedef struct packed {
    logic               busy;
    logic signed [31:0] cos_q30;
    logic signed [31:0] sin_q30;
  } odo_trig_t;

  typedef struct packed {
    logic             busy;
    logic [NUM_W-1:0] q;
  } odo_quot_t;

  // round(atan(2^-i) * 2^24)
  function automatic logic signed [27:0] atan_q24(input logic [4:0] idx);
    logic signed [27:0] v;
    case (idx)
      5'd0:  v = 28'sd13176795;
      5'd1:  v = 28'sd7778716;
      5'd2:  v = 28'sd4110060;
      5'd3:  v = 28'sd2086331;
      5'd4:  v = 28'sd1047214;
      5'd5:  v = 28'sd524117;
      5'd6:  v = 28'sd262123;
      5'd7:  v = 28'sd131069;
      5'd8:  v = 28'sd65536;
      5'd9:  v = 28'sd32768;
      5'd10: v = 28'sd16384;
      5'd11: v = 28'sd8192;
      5'd12: v = 28'sd4096;
      5'd13: v = 28'sd2048;
      5'd14: v = 28'sd1024;
      5'd15: v = 28'sd512;
      5'd16: v = 28'sd256;
      5'd17: v = 28'sd128;
      5'd18: v = 28'sd64;
      5'd19: v = 28'sd32;
      5'd20: v = 28'sd16;
      5'd21: v = 28'sd8;
      5'd22: v = 28'sd4;
      5'd23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // clamp to the int32 range
  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -48'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/odo_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module odo_mul (
  input  wire logic                                 clk,
  input  wire logic signed [odo_pkg::MUL_A_W-1:0]   a,
  input  wire logic signed [odo_pkg::MUL_B_W-1:0]   b,
  output logic signed [odo_pkg::MUL_P_W-1:0]        p
);
  import odo_pkg::*;

  // registered signed product
  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

`default_nettype wire

// File: rtl/odo_div.sv
`timescale 1ns / 1ps
`default_nettype none

module odo_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [odo_pkg::NUM_W-1:0]  num,
  input  wire logic [15:0]                den,
  output odo_pkg::odo_quot_t              quot
);
  import odo_pkg::*;

  logic [DCNT_W-1:0] cnt;
  logic [NUM_W-1:0]  work;
  logic [15:0]       rem;
  logic [15:0]       den_r;
  logic [16:0]       trial;
  logic              fits;

  // one restoring step: bring down the next numerator bit
  assign trial = {rem, work[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DCNT_W'(NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  // quotient bits shift in where numerator bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      work  <= num;
      rem   <= '0;
      den_r <= den;
    end else if (cnt != '0) begin
      work <= {work[NUM_W-2:0], fits};
      rem  <= fits ? 16'(trial - {1'b0, den_r}) : trial[15:0];
    end
  end

  assign quot.busy = cnt != '0;
  assign quot.q    = work;

endmodule

`default_nettype wire

// File: rtl/odo_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module odo_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] angle,
  output odo_pkg::odo_trig_t      trig
);
  import odo_pkg::*;

  localparam int            IW   = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [IW-1:0] LAST = IW'(CORDIC_STEPS - 1);

  odo_cordic_state_t state, state_next;

  logic [2:0]               k;
  logic [IW-1:0]            iter;
  logic [31:0]              rem;
  logic [31:0]              sub;
  logic                     neg_in;
  logic                     negate;
  logic signed [ANG_W-1:0]  r;
  logic signed [ANG_W-1:0]  r_wrap;
  logic signed [ANG_W-1:0]  at;
  logic signed [XY_W-1:0]   x;
  logic signed [XY_W-1:0]   y;
  logic signed [XY_W-1:0]   x_sh;
  logic signed [XY_W-1:0]   y_sh;
  logic signed [XY_W-1:0]   cos_full;
  logic signed [XY_W-1:0]   sin_full;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: reduce, fold, wrap, then rotate
  always_comb begin
    state_next = state;
    case (state)
      C_IDLE:   if (start) state_next = C_REDUCE;
      C_REDUCE: if (k == 3'd0) state_next = C_FOLD;
      C_FOLD:   state_next = C_WRAP;
      C_WRAP:   state_next = C_ROTATE;
      C_ROTATE: if (iter == LAST) state_next = C_IDLE;
      default:  state_next = C_IDLE;
    endcase
  end

  // shared shift and add terms
  assign sub    = TWO_PI_MOD << k;
  assign r_wrap = (r > PI_Q24) ? r - TWO_PI_Q24 : r;
  assign at     = atan_q24(5'(iter));
  assign x_sh   = x >>> iter;
  assign y_sh   = y >>> iter;

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        if (start) begin
          rem    <= 32'(angle[31] ? -angle : angle);
          neg_in <= angle[31];
          k      <= 3'd5;
        end
      end
      // magnitude modulo 2*pi, one scaled subtract per cycle
      C_REDUCE: begin
        if (rem >= sub) begin
          rem <= rem - sub;
        end
        k <= k - 1'b1;
      end
      // floor remainder into [0, 2*pi)
      C_FOLD: begin
        if (neg_in && rem != '0) begin
          r <= ANG_W'(TWO_PI_MOD - rem);
        end else begin
          r <= ANG_W'(rem);
        end
      end
      // into [-pi, pi], then fold the outer quadrants by pi
      C_WRAP: begin
        x    <= CORDIC_START;
        y    <= '0;
        iter <= '0;
        if (r_wrap > HALF_PI_Q24) begin
          r      <= r_wrap - PI_Q24;
          negate <= 1'b1;
        end else if (r_wrap < -HALF_PI_Q24) begin
          r      <= r_wrap + PI_Q24;
          negate <= 1'b1;
        end else begin
          r      <= r_wrap;
          negate <= 1'b0;
        end
      end
      // one micro-rotation per cycle
      C_ROTATE: begin
        if (!r[ANG_W-1]) begin
          x <= x - y_sh;
          y <= y + x_sh;
          r <= r - at;
        end else begin
          x <= x + y_sh;
          y <= y - x_sh;
          r <= r + at;
        end
        iter <= iter + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign cos_full     = negate ? -x : x;
  assign sin_full     = negate ? -y : y;
  assign trig.busy    = state != C_IDLE;
  assign trig.cos_q30 = cos_full[31:0];
  assign trig.sin_q30 = sin_full[31:0];

endmodule

`default_nettype wire

// File: rtl/differential_drive_odometry_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Differential-drive odometry: each step item scales the two wheel angle deltas by the
// wheel radius, moves x and y by the mean travel along the old heading and turns the
// heading by the travel difference over the axle length; a clear item zeroes the pose.
// Every item gives one result with the new pose, saturated at the int32 limits. A step
// item is paced by the 45-step restoring divider for the heading increment, while the
// CORDIC and the four partial products on the shared 35x17 multiplier run alongside it.
// A clear item goes straight to the finish state. The next item is taken once the
// previous result has entered the output register, even if that result is still stalled.
module differential_drive_odometry_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wen,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               kind,
  input  wire logic signed [15:0] left_delta,
  input  wire logic signed [15:0] right_delta,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      pos_x_out,
  output logic signed [31:0]      pos_y_out,
  output logic signed [31:0]      heading_out
);
  import odo_pkg::*;

  odo_state_t state, state_next;

  logic [15:0]               radius;
  logic [15:0]               axle_length;
  logic signed [31:0]        pos_x;
  logic signed [31:0]        pos_y;
  logic signed [31:0]        heading;
  logic                      is_clear;
  logic signed [15:0]        ld;
  logic signed [15:0]        rd;
  logic signed [33:0]        sum;
  logic signed [33:0]        diff;
  logic signed [ACC_W-1:0]   acc_x;
  logic signed [ACC_W-1:0]   acc_y;

  logic                      in_accept;
  logic                      load_out;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic signed [33:0]        diff_now;
  logic [31:0]               diff_mag;
  logic [15:0]               axle_eff;
  logic [NUM_W-1:0]          div_num;
  odo_trig_t                 trig;
  odo_quot_t                 quot;
  logic signed [ACC_W-1:0]   rx;
  logic signed [ACC_W-1:0]   ry;
  logic signed [24:0]        dx;
  logic signed [24:0]        dy;
  logic signed [46:0]        dh;
  logic signed [31:0]        new_x;
  logic signed [31:0]        new_y;
  logic signed [31:0]        new_h;

  assign in_stall  = state != S_IDLE;
  assign in_accept = in_valid && !in_stall;
  assign load_out  = (state == S_FINISH) && !(out_valid && out_stall);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius      <= RADIUS_RESET;
      axle_length <= AXLE_RESET;
    end else if (cfg_wen) begin
      case (odo_cfg_t'(cfg_index))
        CFG_WHEEL_RADIUS: radius      <= cfg_data;
        CFG_AXLE_LENGTH:  axle_length <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer and multiplier operand select
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = kind ? S_FINISH : S_TRAV_SUM;
        end
      end
      S_TRAV_SUM: begin
        mul_a      = MUL_A_W'(ld) + MUL_A_W'(rd);
        mul_b      = {1'b0, radius};
        state_next = S_TRAV_DIFF;
      end
      S_TRAV_DIFF: begin
        mul_a      = MUL_A_W'(rd) - MUL_A_W'(ld);
        mul_b      = {1'b0, radius};
        state_next = S_TRAV_DONE;
      end
      S_TRAV_DONE: state_next = S_WAIT_CORDIC;
      S_WAIT_CORDIC: begin
        if (!trig.busy) state_next = S_X_LO;
      end
      S_X_LO: begin
        mul_a      = MUL_A_W'(sum);
        mul_b      = {1'b0, trig.cos_q30[15:0]};
        state_next = S_X_HI;
      end
      S_X_HI: begin
        mul_a      = MUL_A_W'(sum);
        mul_b      = {trig.cos_q30[31], trig.cos_q30[31:16]};
        state_next = S_Y_LO;
      end
      S_Y_LO: begin
        mul_a      = MUL_A_W'(sum);
        mul_b      = {1'b0, trig.sin_q30[15:0]};
        state_next = S_Y_HI;
      end
      S_Y_HI: begin
        mul_a      = MUL_A_W'(sum);
        mul_b      = {trig.sin_q30[31], trig.sin_q30[31:16]};
        state_next = S_Y_DONE;
      end
      S_Y_DONE: state_next = S_WAIT_DIV;
      S_WAIT_DIV: begin
        if (!quot.busy) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  odo_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  odo_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (in_accept && !kind),
    .angle (heading),
    .trig  (trig)
  );

  // rounded |diff| * 2^12 / axle, zero axle taken as one
  assign diff_now = mul_p[33:0];
  assign diff_mag = 32'(diff_now[33] ? -diff_now : diff_now);
  assign axle_eff = (axle_length == '0) ? 16'd1 : axle_length;
  assign div_num  = NUM_W'({diff_mag, 12'b0}) + NUM_W'(axle_eff >> 1);

  odo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_TRAV_DONE),
    .num   (div_num),
    .den   (axle_eff),
    .quot  (quot)
  );

  // item datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          is_clear <= kind;
          ld       <= left_delta;
          rd       <= right_delta;
        end
      end
      S_TRAV_DIFF: sum   <= mul_p[33:0];
      S_TRAV_DONE: diff  <= diff_now;
      S_X_HI:      acc_x <= ACC_W'(mul_p);
      S_Y_LO:      acc_x <= acc_x + (ACC_W'(mul_p) <<< 16);
      S_Y_HI:      acc_y <= ACC_W'(mul_p);
      S_Y_DONE:    acc_y <= acc_y + (ACC_W'(mul_p) <<< 16);
      default: begin
      end
    endcase
  end

  // round half up, then saturating pose update
  assign rx    = acc_x + (ACC_W'(1) <<< 42);
  assign ry    = acc_y + (ACC_W'(1) <<< 42);
  assign dx    = rx[ACC_W-1:43];
  assign dy    = ry[ACC_W-1:43];
  assign dh    = diff[33] ? -{2'b00, quot.q} : {2'b00, quot.q};
  assign new_x = is_clear ? '0 : sat32(48'(pos_x) + 48'(dx));
  assign new_y = is_clear ? '0 : sat32(48'(pos_y) + 48'(dy));
  assign new_h = is_clear ? '0 : sat32(48'(heading) + 48'(dh));

  // pose registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x   <= '0;
      pos_y   <= '0;
      heading <= '0;
    end else if (load_out) begin
      pos_x   <= new_x;
      pos_y   <= new_y;
      heading <= new_h;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      pos_x_out   <= new_x;
      pos_y_out   <= new_y;
      heading_out <= new_h;
    end
  end

  // units are finished whenever the sequencer rests
  a_units_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !trig.busy && !quot.busy)
    else $error("arithmetic unit busy while sequencer idle");

  // a step item starts the cordic
  a_cordic_start: assert property (@(posedge clk) disable iff (rst)
    in_accept && !kind |=> trig.busy)
    else $error("cordic not started on step item");

  // a result appears only out of the finish state
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result raised outside finish state");

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import odo_pkg::*;

  // trig and angle constants, heading units of 2^-24 rad
  localparam int     TRIG_STEPS   = 16;
  localparam int     TRIG_TAB     = 24;
  localparam longint FULL_TURN    = 64'sd105414357;
  localparam longint HALF_TURN    = 64'sd52707179;
  localparam longint QUARTER_TURN = 64'sd26353589;
  localparam longint GAIN_INV     = 64'sd652032874;
  localparam longint ROUND_HALF   = 64'sd4398046511104;

  // item kinds
  localparam logic KIND_STEP  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // run control
  localparam int SETTLE_CYCLES    = 64;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int IDLE_PCT         = 30;
  localparam int MAX_PRINTS       = 100;
  localparam int PHASE_ITEMS      = 80;
  localparam int HOLD_CYCLES      = 400;
  localparam int FULL_SPEED_ITEMS = 20;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] h;
  } pose_t;

  logic               clk;
  logic               rst;
  logic               cfg_wen;
  logic               cfg_index;
  logic [15:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic               kind;
  logic signed [15:0] left_delta;
  logic signed [15:0] right_delta;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] pos_x_out;
  logic signed [31:0] pos_y_out;
  logic signed [31:0] heading_out;

  // predicted geometry and pose
  logic [15:0]        radius_m = RADIUS_RESET;
  logic [15:0]        axle_m   = AXLE_RESET;
  logic signed [31:0] x_m      = '0;
  logic signed [31:0] y_m      = '0;
  logic signed [31:0] h_m      = '0;

  longint atan_tab_q24 [0:TRIG_TAB-1] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  pose_t expected_poses[$];
  int    error_count = 0;
  int    cycle_count = 0;
  int    hold_left   = 0;
  bit    quiet       = 1'b0;

  differential_drive_odometry_core #(
    .CORDIC_STEPS(TRIG_STEPS)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .left_delta (left_delta),
    .right_delta(right_delta),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pos_x_out  (pos_x_out),
    .pos_y_out  (pos_y_out),
    .heading_out(heading_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // add with clamp to the int32 range
  function automatic logic signed [31:0] clamp_add(input logic signed [31:0] base,
                                                   input longint inc);
    longint t;
    t = longint'(base) + inc;
    if (t > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (t < -64'sd2147483648) return 32'sh80000000;
    return t[31:0];
  endfunction

  // cosine and sine of the heading in Q2.30 by rotation cordic
  function automatic void heading_trig(input logic signed [31:0] h,
                                       output longint c, output longint s);
    longint r;
    longint px;
    longint py;
    longint nx;
    bit     flip;
    r    = longint'(h) % FULL_TURN;
    px   = GAIN_INV;
    py   = 0;
    flip = 1'b0;
    // fold into [-pi/2, pi/2]
    if (r < 0) r += FULL_TURN;
    if (r > HALF_TURN) r -= FULL_TURN;
    if (r > QUARTER_TURN) begin
      r -= HALF_TURN;
      flip = 1'b1;
    end else if (r < -QUARTER_TURN) begin
      r += HALF_TURN;
      flip = 1'b1;
    end
    for (int i = 0; i < TRIG_STEPS && i < TRIG_TAB; i++) begin
      if (r >= 0) begin
        nx = px - (py >>> i);
        py = py + (px >>> i);
        r -= atan_tab_q24[i];
      end else begin
        nx = px + (py >>> i);
        py = py - (px >>> i);
        r += atan_tab_q24[i];
      end
      px = nx;
    end
    c = flip ? -px : px;
    s = flip ? -py : py;
  endfunction

  // new pose after one item
  function automatic pose_t advance_pose(input logic k, input logic signed [15:0] l,
                                         input logic signed [15:0] r);
    longint tl;
    longint tr;
    longint sum;
    longint diff;
    longint c;
    longint s;
    longint a;
    longint mag;
    longint dh;
    pose_t  p;
    if (k == KIND_CLEAR) begin
      x_m = '0;
      y_m = '0;
      h_m = '0;
    end else begin
      tl   = longint'(l) * longint'(radius_m);
      tr   = longint'(r) * longint'(radius_m);
      sum  = tl + tr;
      diff = tr - tl;
      a    = (axle_m == 16'd0) ? 64'sd1 : longint'(axle_m);
      heading_trig(h_m, c, s);
      // heading turn rounds half away from zero
      mag  = (diff < 0) ? -diff : diff;
      mag  = ((mag <<< 12) + a / 2) / a;
      dh   = (diff < 0) ? -mag : mag;
      x_m  = clamp_add(x_m, (sum * c + ROUND_HALF) >>> 43);
      y_m  = clamp_add(y_m, (sum * s + ROUND_HALF) >>> 43);
      h_m  = clamp_add(h_m, dh);
    end
    p.x = x_m;
    p.y = y_m;
    p.h = h_m;
    return p;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) $display("error at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic signed [31:0] got,
                             input logic signed [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // result checking, register tracking and prediction on accepted items
  always @(posedge clk) begin
    pose_t want;
    cycle_count++;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_poses.size() == 0) begin
          report_mismatch($sformatf("unexpected item x %0d y %0d heading %0d",
                                    pos_x_out, pos_y_out, heading_out));
        end else begin
          want = expected_poses.pop_front();
          check_field("pos_x_out", pos_x_out, want.x);
          check_field("pos_y_out", pos_y_out, want.y);
          check_field("heading_out", heading_out, want.h);
        end
      end
      if (cfg_wen) begin
        case (odo_cfg_t'(cfg_index))
          CFG_WHEEL_RADIUS: radius_m = cfg_data;
          CFG_AXLE_LENGTH:  axle_m   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_poses.push_back(advance_pose(kind, left_delta, right_delta));
      end
    end
  end

  // receiver: random stalls, long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (quiet) begin
      out_stall = 1'b0;
    end else begin
      out_stall = ($urandom_range(99) < IDLE_PCT);
    end
  end

  // hang guard
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("differential_drive_odometry_core: mismatch");
    $finish;
  end

  task automatic send_item(input logic k, input logic signed [15:0] l,
                           input logic signed [15:0] r);
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    @(negedge clk);
    kind        = k;
    left_delta  = l;
    right_delta = r;
    in_valid    = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and wait for every expected result
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input odo_cfg_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_wen   = 1'b0;
    cfg_data  = 16'($urandom);
  endtask

  task automatic set_geometry(input logic [15:0] radius, input logic [15:0] axle);
    write_reg(CFG_WHEEL_RADIUS, radius);
    write_reg(CFG_AXLE_LENGTH, axle);
  endtask

  // mix of extremes, small turns and full-range deltas
  function automatic logic signed [15:0] random_delta();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      case ($urandom_range(3))
        0: return 16'sh7FFF;
        1: return 16'sh8000;
        2: return 16'sh0000;
        default: return 16'shFFFF;
      endcase
    end
    if (pick <= 2) return 16'(int'($urandom_range(128)) - 64);
    return 16'($urandom);
  endfunction

  task automatic send_random_item();
    logic signed [15:0] l;
    logic signed [15:0] r;
    int                 shape;
    l     = random_delta();
    shape = $urandom_range(99);
    if (shape < 15) r = l;
    else if (shape < 25) r = -l;
    else r = random_delta();
    send_item(($urandom_range(99) < 5) ? KIND_CLEAR : KIND_STEP, l, r);
  endtask

  // reset geometry, straight and turning moves, clear with deltas present
  task automatic test_reset_geometry();
    send_item(KIND_STEP, 16'sd100, 16'sd100);
    send_item(KIND_STEP, -16'sd50, 16'sd200);
    send_item(KIND_STEP, 16'sh7FFF, 16'sh7FFF);
    send_item(KIND_CLEAR, 16'sd1234, -16'sd1234);
    drain_results();
  endtask

  // delta extremes at both ends of the geometry range
  task automatic test_field_extremes();
    set_geometry(16'hFFFF, 16'hFFFF);
    send_item(KIND_STEP, 16'sh7FFF, 16'sh7FFF);
    send_item(KIND_STEP, 16'sh8000, 16'sh8000);
    send_item(KIND_STEP, 16'sh7FFF, 16'sh8000);
    send_item(KIND_STEP, 16'sh8000, 16'sh7FFF);
    send_item(KIND_STEP, 16'sd0, 16'sd0);
    send_item(KIND_STEP, -16'sd1, 16'sd1);
    send_item(KIND_CLEAR, 16'sh8000, 16'sh7FFF);
    drain_results();
    // several turns of heading, exercises the angle reduction
    set_geometry(16'd1, 16'd1);
    send_item(KIND_STEP, 16'sh7FFF, 16'sh8000);
    send_item(KIND_STEP, 16'sd1, 16'sd1);
    send_item(KIND_STEP, 16'sh8000, 16'sh8000);
    drain_results();
  endtask

  // zero radius, zero axle and heading clamped both ways
  task automatic test_register_corners();
    set_geometry(16'd0, AXLE_RESET);
    send_item(KIND_STEP, 16'sd12345, -16'sd3000);
    drain_results();
    set_geometry(16'hFFFF, 16'd0);
    send_item(KIND_STEP, 16'sh8000, 16'sh7FFF);
    send_item(KIND_STEP, 16'sd100, 16'sd100);
    send_item(KIND_STEP, 16'sh7FFF, 16'sh8000);
    send_item(KIND_STEP, 16'sh7FFF, 16'sh8000);
    send_item(KIND_STEP, 16'sd200, -16'sd50);
    send_item(KIND_CLEAR, 16'sd0, 16'sd0);
    drain_results();
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_backpressure();
    set_geometry(RADIUS_RESET, AXLE_RESET);
    quiet     = 1'b1;
    hold_left = HOLD_CYCLES;
    repeat (12) send_random_item();
    quiet = 1'b0;
    drain_results();
  endtask

  // drive diagonally at full speed with no idling on either side, then back off
  task automatic test_full_speed();
    set_geometry(16'hFFFF, 16'hFFFF);
    quiet = 1'b1;
    send_item(KIND_CLEAR, 16'sd0, 16'sd0);
    // about pi/4 of heading
    send_item(KIND_STEP, 16'sd0, 16'sd3217);
    repeat (FULL_SPEED_ITEMS) send_item(KIND_STEP, 16'sh7FFF, 16'sh7FFF);
    quiet = 1'b0;
    repeat (3) send_item(KIND_STEP, 16'sh8000, 16'sh8000);
    send_item(KIND_CLEAR, 16'sd0, 16'sd0);
    drain_results();
  endtask

  // random items over several geometry settings, with a pause mid-phase
  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_geometry(16'hFFFF, 16'd1);
        1: set_geometry(16'd1, 16'hFFFF);
        2: set_geometry(RADIUS_RESET, AXLE_RESET);
        3: set_geometry(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)));
        default: set_geometry(16'($urandom), 16'($urandom));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain_results();
        send_random_item();
      end
      drain_results();
    end
  endtask

  initial begin
    rst         = 1'b1;
    cfg_wen     = 1'b0;
    cfg_index   = CFG_WHEEL_RADIUS;
    cfg_data    = '0;
    in_valid    = 1'b0;
    kind        = KIND_STEP;
    left_delta  = '0;
    right_delta = '0;
    out_stall   = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_geometry();
    test_field_extremes();
    test_register_corners();
    test_backpressure();
    test_full_speed();
    test_random_traffic();

    drain_results();
    if (error_count == 0) begin
      $display("differential_drive_odometry_core: match");
    end else begin
      $display("differential_drive_odometry_core: mismatch");
    end
    $finish;
  end

endmodule
